@@ design/pms_pkg.sv @@
// shared types and codes for the partitioned multi-stack
package pms_pkg;

  localparam int REC_W      = 31;
  localparam int SCORE_W    = 32;
  localparam int STACK_ID_W = 4;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ADDR_PUSH = 2'd0,
    ADDR_TOP  = 2'd1,
    ADDR_NEXT = 2'd2
  } addr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_t;

  typedef struct packed {
    logic      load;
    logic      ram_we;
    logic      ram_re;
    addr_sel_t addr_sel;
    cnt_op_t   cnt_op;
    logic      rd_load;
    logic      rd_step;
    logic      emit;
    status_t   emit_status;
    logic      emit_data;
    logic      emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic    id_ok;
    action_t action;
    logic    full;
    logic    empty;
    logic    rd_last;
  } ctrl_stat_t;

endpackage

@@ design/pms_ram.sv @@
// generic simple dual-port ram with registered read
module pms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/pms_datapath.sv @@
// datapath: command capture, fill counts, entry ram, read cursor and result registers
module pms_datapath #(
  parameter int NUM_STACKS    = 8,
  parameter int TOTAL_ENTRIES = 128,
  parameter int DATA_WIDTH    = 63
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pms_pkg::ctrl_cmd_t                  cmd,
  output pms_pkg::ctrl_stat_t                 stat,
  input  logic [1:0]                          action,
  input  logic [pms_pkg::STACK_ID_W-1:0]      stack_id,
  input  logic [pms_pkg::REC_W-1:0]           record_number,
  input  logic [pms_pkg::SCORE_W-1:0]         score_bits,
  output logic                                valid,
  output logic [1:0]                          status,
  output logic [pms_pkg::REC_W-1:0]           out_record,
  output logic [pms_pkg::SCORE_W-1:0]         out_score,
  output logic                                last
);
  import pms_pkg::*;

  localparam int PART_SIZE = TOTAL_ENTRIES / NUM_STACKS;
  localparam int CNT_W     = (PART_SIZE > 0) ? $clog2(PART_SIZE + 1) : 1;
  localparam int OFF_W     = (PART_SIZE > 1) ? $clog2(PART_SIZE) : 1;
  localparam int ADDR_W    = (TOTAL_ENTRIES > 1) ? $clog2(TOTAL_ENTRIES) : 1;
  localparam int SID_W     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [CNT_W-1:0] PART_CNT = CNT_W'(PART_SIZE);

  action_t                 action_q;
  logic [STACK_ID_W-1:0]   id_q;
  logic [REC_W-1:0]        rec_q;
  logic [SCORE_W-1:0]      score_q;
  logic [CNT_W-1:0]        counts [NUM_STACKS];
  logic [OFF_W-1:0]        off;
  logic [CNT_W-1:0]        remain;

  logic                    id_ok;
  logic [SID_W-1:0]        sidx;
  logic [CNT_W-1:0]        fill;
  logic [CNT_W-1:0]        fill_m1;
  logic [ADDR_W-1:0]       base;
  logic [ADDR_W-1:0]       addr;
  logic [DATA_WIDTH-1:0]   wdata;
  logic [DATA_WIDTH-1:0]   rdata;
  logic [63:0]             wword;
  logic [63:0]             rword;

  // capture the command beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_q <= action_t'(action);
      id_q     <= stack_id;
      rec_q    <= record_number;
      score_q  <= score_bits;
    end
  end

  assign id_ok   = {1'b0, id_q} < (STACK_ID_W + 1)'(NUM_STACKS);
  assign sidx    = id_q[SID_W-1:0];
  assign fill    = id_ok ? counts[sidx] : '0;
  assign fill_m1 = fill - CNT_W'(1);
  assign base    = ADDR_W'(id_q * PART_SIZE);

  always_comb begin
    case (cmd.addr_sel)
      ADDR_PUSH: addr = base + ADDR_W'(fill);
      ADDR_TOP:  addr = base + ADDR_W'(fill) - ADDR_W'(1);
      ADDR_NEXT: addr = base + ADDR_W'(off) - ADDR_W'(1);
      default:   addr = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      case (cmd.cnt_op)
        CNT_INC:  counts[sidx] <= fill + CNT_W'(1);
        CNT_DEC:  counts[sidx] <= fill_m1;
        CNT_CLR:  counts[sidx] <= '0;
        default:  ;
      endcase
    end
  end

  // read-out cursor walks from the top entry down to the bottom
  always_ff @(posedge clk) begin
    if (cmd.rd_load) begin
      off    <= fill_m1[OFF_W-1:0];
      remain <= fill;
    end else if (cmd.rd_step) begin
      off    <= off - OFF_W'(1);
      remain <= remain - CNT_W'(1);
    end
  end

  // entry layout: record in the low bits, score above it
  assign wword = {1'b0, score_q, rec_q};
  assign wdata = wword[DATA_WIDTH-1:0];
  assign rword = 64'(rdata);

  pms_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (TOTAL_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (addr),
    .wdata (wdata),
    .re    (cmd.ram_re),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status     <= cmd.emit_status;
      last       <= cmd.emit_last;
      out_record <= cmd.emit_data ? rword[REC_W-1:0] : '0;
      out_score  <= cmd.emit_data ? rword[REC_W+SCORE_W-1:REC_W] : '0;
    end
  end

  assign stat.id_ok   = id_ok;
  assign stat.action  = action_q;
  assign stat.full    = fill >= PART_CNT;
  assign stat.empty   = fill == '0;
  assign stat.rd_last = remain == CNT_W'(1);

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    id_ok |-> fill <= PART_CNT)
    else $error("fill count beyond partition size");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ram_we && cmd.ram_re))
    else $error("ram written and read in one cycle");

  a_readout_burst: assert property (@(posedge clk) disable iff (rst)
    valid && !last |=> valid)
    else $error("gap inside a read-out burst");

endmodule

@@ design/pms_controller.sv @@
// controller: sequences one command through check, ram access and result beats
module pms_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pms_pkg::ctrl_stat_t stat,
  output pms_pkg::ctrl_cmd_t  cmd
);
  import pms_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_POP   = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != S_IDLE;

  always_comb begin
    cmd         = '0;
    cmd.load    = start && !busy;
    state_next  = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next      = S_IDLE;
        cmd.emit        = 1'b1;
        cmd.emit_last   = 1'b1;
        cmd.emit_status = ST_OK;
        if (!stat.id_ok) begin
          cmd.emit_status = ST_INVALID;
        end else begin
          case (stat.action)
            ACT_PUSH: begin
              if (stat.full) begin
                cmd.emit_status = ST_FULL;
              end else begin
                cmd.ram_we   = 1'b1;
                cmd.addr_sel = ADDR_PUSH;
                cmd.cnt_op   = CNT_INC;
              end
            end
            ACT_POP: begin
              if (stat.empty) begin
                cmd.emit_status = ST_EMPTY;
              end else begin
                cmd.emit     = 1'b0;
                cmd.ram_re   = 1'b1;
                cmd.addr_sel = ADDR_TOP;
                cmd.cnt_op   = CNT_DEC;
                state_next   = S_POP;
              end
            end
            ACT_CLEAR: begin
              cmd.cnt_op = CNT_CLR;
            end
            default: begin
              if (stat.empty) begin
                cmd.emit_status = ST_EMPTY;
              end else begin
                cmd.emit     = 1'b0;
                cmd.ram_re   = 1'b1;
                cmd.addr_sel = ADDR_TOP;
                cmd.rd_load  = 1'b1;
                state_next   = S_DRAIN;
              end
            end
          endcase
        end
      end
      S_POP: begin
        cmd.emit        = 1'b1;
        cmd.emit_data   = 1'b1;
        cmd.emit_last   = 1'b1;
        cmd.emit_status = ST_OK;
        state_next      = S_IDLE;
      end
      S_DRAIN: begin
        // each cycle sends the entry read last cycle and fetches the one below
        cmd.emit        = 1'b1;
        cmd.emit_data   = 1'b1;
        cmd.emit_status = ST_OK;
        cmd.emit_last   = stat.rd_last;
        if (stat.rd_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.ram_re   = 1'b1;
          cmd.addr_sel = ADDR_NEXT;
          cmd.rd_step  = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == S_EXEC)
    else $error("accepted command not executed");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.emit_last |=> state == S_IDLE)
    else $error("command did not end after its last beat");

  a_ram_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.ram_we || cmd.ram_re) |-> busy)
    else $error("ram access while idle");

endmodule

@@ design/partitioned_multi_stack.sv @@
// top level of the partitioned multi-stack
// Several stacks share one entry ram, split into equal fixed partitions of
// TOTAL_ENTRIES / NUM_STACKS entries. A command beat is taken when start is
// high and busy is low; each result is shown for one cycle with valid high and
// cannot be held off, so the receiver must take every beat. Invalid stack
// numbers, push to a full stack, pop or read-out of an empty stack, clear and a
// good push end in the EXEC state with one registered result and keep busy high
// for a single cycle, so a new command can be taken once busy falls. A pop
// passes through the extra state S_POP, because the entry ram has a
// registered read. A read-out of n entries gives n back-to-back results, top
// first with last on the bottom one; the single read port of the entry ram
// sets one entry per cycle. The entry ram needs no clearing after reset: only
// entries below a stack's fill count are ever read.
module partitioned_multi_stack #(
  parameter int NUM_STACKS    = 8,
  parameter int TOTAL_ENTRIES = 128,
  parameter int DATA_WIDTH    = 63
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     action,
  input  logic [pms_pkg::STACK_ID_W-1:0] stack_id,
  input  logic [pms_pkg::REC_W-1:0]      record_number,
  input  logic [pms_pkg::SCORE_W-1:0]    score_bits,
  output logic                           valid,
  output logic [1:0]                     status,
  output logic [pms_pkg::REC_W-1:0]      out_record,
  output logic [pms_pkg::SCORE_W-1:0]    out_score,
  output logic                           last
);
  import pms_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  pms_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  pms_datapath #(
    .NUM_STACKS    (NUM_STACKS),
    .TOTAL_ENTRIES (TOTAL_ENTRIES),
    .DATA_WIDTH    (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .action        (action),
    .stack_id      (stack_id),
    .record_number (record_number),
    .score_bits    (score_bits),
    .valid         (valid),
    .status        (status),
    .out_record    (out_record),
    .out_score     (out_score),
    .last          (last)
  );

endmodule
